[hdl/grid_flood_fill_defines.svh]
// ---------------------------------------------------------------------------
// Grid flood fill assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef GRID_FLOOD_FILL_DEFINES_SVH
`define GRID_FLOOD_FILL_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define GFF_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define GFF_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hdl/gff_pkg.sv]
// ---------------------------------------------------------------------------
// Grid flood fill package
// Operation codes, tile width and neighbor directions for the flood fill.
// ---------------------------------------------------------------------------
package gff_pkg;

  // Width of one tile value and of the incoming coordinates.
  localparam int TILE_W  = 8;
  localparam int COORD_W = 6;
  localparam int OP_W    = 2;

  // Operation codes; the unused code behaves as a read.
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_FILL  = 2'd2;

  // Order in which the four neighbors of a popped cell are visited.
  typedef enum logic [1:0] {
    DIR_UP,
    DIR_DOWN,
    DIR_LEFT,
    DIR_RIGHT
  } dir_t;

endpackage

[hdl/grid_flood_fill.sv]
// A write or read passes the read, evaluate and done states before its result is registered;
// an off-grid cell goes straight to done. A fill pops each queued cell, then reads and checks
// each in-grid neighbor in turn; the single grid RAM read port serializes these steps.
// Throughput: one item at a time; the next is accepted once the current result is registered.
// Reset: rst_n clears control state, then a clearing pass writes zero to all
// GRID_COLS*GRID_ROWS cells, one per cycle, with input stalled until it ends.
// ---------------------------------------------------------------------------
// Grid flood fill
// Tile grid with cell write, cell read and 4-connected breadth-first flood
// fill driven by a small sequencer over one grid RAM and one work queue RAM.
// ---------------------------------------------------------------------------
`include "grid_flood_fill_defines.svh"

module grid_flood_fill #(
  parameter int GRID_COLS   = 64,
  parameter int GRID_ROWS   = 64,
  parameter int TILE_KINDS  = 256,
  parameter int QUEUE_DEPTH = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [gff_pkg::OP_W-1:0]     in_op,
  input  logic [gff_pkg::COORD_W-1:0]  in_cell_x,
  input  logic [gff_pkg::COORD_W-1:0]  in_cell_y,
  input  logic [gff_pkg::TILE_W-1:0]   in_tile_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gff_pkg::TILE_W-1:0]   out_old_value,
  output logic                         out_changed
);

  localparam int CELLS   = GRID_COLS * GRID_ROWS;
  localparam int AW      = $clog2(CELLS);
  localparam int XW      = $clog2(GRID_COLS);
  localparam int YW      = $clog2(GRID_ROWS);
  localparam int QEW     = XW + YW;
  localparam int QAW     = $clog2(QUEUE_DEPTH);
  localparam int QCW     = $clog2(QUEUE_DEPTH + 1);
  localparam int VAL_TOP = (TILE_KINDS - 1 > 255) ? 255 : TILE_KINDS - 1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_POP,
    S_POPW,
    S_NREAD,
    S_NCHK,
    S_DONE
  } state_t;

  state_t                     state_r, state_nxt;
  logic [AW-1:0]              clr_addr_r, clr_addr_nxt;
  logic [gff_pkg::OP_W-1:0]   op_r, op_nxt;
  logic [gff_pkg::TILE_W-1:0] val_r, val_nxt;
  logic [XW-1:0]              x_r, x_nxt;
  logic [YW-1:0]              y_r, y_nxt;
  logic [AW-1:0]              addr_r, addr_nxt;
  logic [gff_pkg::TILE_W-1:0] res_old_r, res_old_nxt;
  logic                       res_chg_r, res_chg_nxt;
  logic [QAW-1:0]             q_head_r, q_head_nxt;
  logic [QAW-1:0]             q_tail_r, q_tail_nxt;
  logic [QCW-1:0]             q_count_r, q_count_nxt;
  logic [XW-1:0]              cx_r, cx_nxt;
  logic [YW-1:0]              cy_r, cy_nxt;
  gff_pkg::dir_t              nbr_r, nbr_nxt;
  logic [AW-1:0]              n_addr_r, n_addr_nxt;
  logic [QEW-1:0]             n_entry_r, n_entry_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [gff_pkg::TILE_W-1:0] out_old_r, out_old_nxt;
  logic                       out_chg_r, out_chg_nxt;

  // RAM ports.
  logic                       g_we;
  logic [AW-1:0]              g_waddr;
  logic [gff_pkg::TILE_W-1:0] g_wdata;
  logic [AW-1:0]              g_raddr;
  logic [gff_pkg::TILE_W-1:0] g_rdata;
  logic                       q_we;
  logic [QAW-1:0]             q_waddr;
  logic [QEW-1:0]             q_wdata;
  logic [QEW-1:0]             q_rdata;

  // Neighbor candidate of the popped cell.
  logic                       n_ok;
  logic [XW-1:0]              n_x;
  logic [YW-1:0]              n_y;
  logic [AW-1:0]              n_addr;

  logic                       in_acc;
  logic                       in_oob;
  logic [gff_pkg::TILE_W-1:0] in_val_cl;
  logic                       push_ok;

  // Linear cell address from column and row.
  function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] cx,
                                              input logic [YW-1:0] cy);
    return AW'(cy * GRID_COLS) + AW'(cx);
  endfunction

  // Queue pointer advance with wrap at the queue depth.
  function automatic logic [QAW-1:0] q_inc(input logic [QAW-1:0] p);
    return (p == QAW'(QUEUE_DEPTH - 1)) ? '0 : p + QAW'(1);
  endfunction

  gff_ram #(
    .WIDTH (gff_pkg::TILE_W),
    .DEPTH (CELLS)
  ) u_grid_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  gff_ram #(
    .WIDTH (QEW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_head_r),
    .rdata (q_rdata)
  );

  // Input transaction decode: bounds check and value clamp.
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_oob    = (32'(in_cell_x) >= GRID_COLS) || (32'(in_cell_y) >= GRID_ROWS);
  assign in_val_cl = (32'(in_tile_value) > VAL_TOP) ? gff_pkg::TILE_W'(VAL_TOP)
                                                    : in_tile_value;

  // Neighbor position and bounds for the current direction.
  always_comb begin
    n_ok = 1'b0;
    n_x  = cx_r;
    n_y  = cy_r;
    case (nbr_r)
      gff_pkg::DIR_UP: begin
        n_ok = (cy_r != '0);
        n_y  = cy_r - YW'(1);
      end
      gff_pkg::DIR_DOWN: begin
        n_ok = (({1'b0, cy_r} + (YW+1)'(1)) < (YW+1)'(GRID_ROWS));
        n_y  = cy_r + YW'(1);
      end
      gff_pkg::DIR_LEFT: begin
        n_ok = (cx_r != '0);
        n_x  = cx_r - XW'(1);
      end
      gff_pkg::DIR_RIGHT: begin
        n_ok = (({1'b0, cx_r} + (XW+1)'(1)) < (XW+1)'(GRID_COLS));
        n_x  = cx_r + XW'(1);
      end
      default: begin
        n_ok = 1'b0;
      end
    endcase
    n_addr = cell_addr(n_x, n_y);
  end

  // A neighbor is filled and queued when it holds the start value and space remains.
  assign push_ok = (g_rdata == res_old_r) && (q_count_r < QCW'(QUEUE_DEPTH));

  // RAM port control.
  always_comb begin
    g_we    = 1'b0;
    g_waddr = addr_r;
    g_wdata = val_r;
    g_raddr = addr_r;
    q_we    = 1'b0;
    q_waddr = q_tail_r;
    q_wdata = n_entry_r;
    case (state_r)
      S_CLEAR: begin
        g_we    = 1'b1;
        g_waddr = clr_addr_r;
        g_wdata = '0;
      end
      S_EVAL: begin
        if (op_r == gff_pkg::OP_WRITE) begin
          g_we = 1'b1;
        end else if (op_r == gff_pkg::OP_FILL && g_rdata != val_r) begin
          g_we    = 1'b1;
          q_we    = 1'b1;
          q_waddr = '0;
          q_wdata = {y_r, x_r};
        end
      end
      S_NREAD: begin
        g_raddr = n_addr;
      end
      S_NCHK: begin
        if (push_ok) begin
          g_we    = 1'b1;
          g_waddr = n_addr_r;
          q_we    = 1'b1;
        end
      end
      default: begin
        g_we = 1'b0;
      end
    endcase
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    op_nxt       = op_r;
    val_nxt      = val_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    addr_nxt     = addr_r;
    res_old_nxt  = res_old_r;
    res_chg_nxt  = res_chg_r;
    q_head_nxt   = q_head_r;
    q_tail_nxt   = q_tail_r;
    q_count_nxt  = q_count_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    nbr_nxt      = nbr_r;
    n_addr_nxt   = n_addr_r;
    n_entry_nxt  = n_entry_r;
    out_old_nxt  = out_old_r;
    out_chg_nxt  = out_chg_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_nxt      = in_op;
          val_nxt     = in_val_cl;
          x_nxt       = XW'(in_cell_x);
          y_nxt       = YW'(in_cell_y);
          addr_nxt    = cell_addr(XW'(in_cell_x), YW'(in_cell_y));
          res_old_nxt = '0;
          res_chg_nxt = 1'b0;
          state_nxt   = in_oob ? S_DONE : S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        res_old_nxt = g_rdata;
        state_nxt   = S_DONE;
        if (op_r == gff_pkg::OP_WRITE) begin
          res_chg_nxt = (g_rdata != val_r);
        end else if (op_r == gff_pkg::OP_FILL && g_rdata != val_r) begin
          // Start cell is recolored and queued; the queue restarts empty.
          res_chg_nxt = 1'b1;
          q_head_nxt  = '0;
          q_tail_nxt  = q_inc('0);
          q_count_nxt = QCW'(1);
          state_nxt   = S_POP;
        end
      end
      S_POP: begin
        if (q_count_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          q_head_nxt  = q_inc(q_head_r);
          q_count_nxt = q_count_r - QCW'(1);
          state_nxt   = S_POPW;
        end
      end
      S_POPW: begin
        cx_nxt    = q_rdata[XW-1:0];
        cy_nxt    = q_rdata[QEW-1:XW];
        nbr_nxt   = gff_pkg::DIR_UP;
        state_nxt = S_NREAD;
      end
      S_NREAD: begin
        if (n_ok) begin
          n_addr_nxt  = n_addr;
          n_entry_nxt = {n_y, n_x};
          state_nxt   = S_NCHK;
        end else if (nbr_r == gff_pkg::DIR_RIGHT) begin
          state_nxt = S_POP;
        end else begin
          nbr_nxt = gff_pkg::dir_t'(nbr_r + 2'd1);
        end
      end
      S_NCHK: begin
        if (push_ok) begin
          q_tail_nxt  = q_inc(q_tail_r);
          q_count_nxt = q_count_r + QCW'(1);
        end
        if (nbr_r == gff_pkg::DIR_RIGHT) begin
          state_nxt = S_POP;
        end else begin
          nbr_nxt   = gff_pkg::dir_t'(nbr_r + 2'd1);
          state_nxt = S_NREAD;
        end
      end
      S_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_old_nxt   = res_old_r;
          out_chg_nxt   = res_chg_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      q_head_r    <= '0;
      q_tail_r    <= '0;
      q_count_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      q_head_r    <= q_head_nxt;
      q_tail_r    <= q_tail_nxt;
      q_count_r   <= q_count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r      <= op_nxt;
    val_r     <= val_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    addr_r    <= addr_nxt;
    res_old_r <= res_old_nxt;
    res_chg_r <= res_chg_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    nbr_r     <= nbr_nxt;
    n_addr_r  <= n_addr_nxt;
    n_entry_r <= n_entry_nxt;
    out_old_r <= out_old_nxt;
    out_chg_r <= out_chg_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_old_value = out_old_r;
  assign out_changed   = out_chg_r;

  // The queue occupancy never exceeds its depth.
  `GFF_ASSERT_ALWAYS(a_q_count_bound, q_count_r <= QCW'(QUEUE_DEPTH), "queue count overflow")

  // An empty queue has its head and tail pointers together.
  `GFF_ASSERT_IMPLY(a_q_empty_ptrs, state_r == S_POP && q_count_r == '0,
                    q_head_r == q_tail_r, "queue pointers disagree with count")

  // A new result appears only right after the sequencer finishes an item.
  `GFF_ASSERT_IMPLY(a_result_from_done, $rose(out_valid_r), $past(state_r == S_DONE),
                    "result raised outside of completion")

  // Flood writes only ever store the fill value over the start value.
  `GFF_ASSERT_IMPLY(a_fill_replaces_start, state_r == S_NCHK && g_we,
                    g_rdata == res_old_r && res_old_r != val_r, "fill wrote a foreign cell")

endmodule

[hdl/gff_ram.sv]
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module gff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
